// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define PLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off while in reset
`define PLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/pls_pkg.sv =====
// shared types and codes for the positional list store
// no dependencies; used by the cell, the top level and the checker
package pls_pkg;

    localparam int OP_W      = 3;
    localparam int POS_W     = 8;
    localparam int VALUE_W   = 32;
    localparam int ST_W      = 2;
    localparam int COUNT_W   = 5;
    localparam int ELEMENT_W = 32;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;
    typedef logic [1:0]      t_cell_kind;

    localparam t_op OP_INS_FRONT = 3'd0;
    localparam t_op OP_INS_BACK  = 3'd1;
    localparam t_op OP_INS_POS   = 3'd2;
    localparam t_op OP_DEL_FRONT = 3'd3;
    localparam t_op OP_DEL_BACK  = 3'd4;
    localparam t_op OP_DEL_POS   = 3'd5;
    localparam t_op OP_SHOW      = 3'd6;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BADPOS = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    localparam t_cell_kind CELL_HOLD   = 2'd0;
    localparam t_cell_kind CELL_INSERT = 2'd1;
    localparam t_cell_kind CELL_DELETE = 2'd2;
    localparam t_cell_kind CELL_ROTATE = 2'd3;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_kind       kind;
        logic [POS_W-1:0] idx;   // slot of insert or delete, 0-based
        logic [POS_W-1:0] tail;  // slot of the last live entry for rotation
    } t_cell_ctl;

endpackage

// ===== rtl/pls_cell.sv =====
// one storage cell of the list chain: holds a single data word
// depends on pls_pkg for the broadcast control struct and its codes
module pls_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_head,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic [DATA_WIDTH-1:0] o_word
);
    import pls_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.kind)
            CELL_INSERT: begin
                if (MY_IDX == i_ctl.idx) begin
                    n_word = i_value;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_word = i_left;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_word = i_right;
                end
            end
            CELL_ROTATE: begin
                if (MY_IDX == i_ctl.tail) begin
                    n_word = i_head;
                end else if (MY_IDX < i_ctl.tail) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== rtl/positional_list_store.sv =====
// positional list store: insert, delete and display take one request each.
// insert and delete finish in the accepting cycle; their result is registered and
// shows the next cycle, so a new request may follow every cycle while the receiver takes
// each result. display enters the show state, then streams one entry per cycle while
// the receiver is ready, limited by the single head cell feeding the output register.
// synchronous active-low reset clears the count, the sequencer and the output valid.
module positional_list_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pls_pkg::OP_W-1:0]          i_op,
    input  logic [pls_pkg::POS_W-1:0]         i_position,
    input  logic [pls_pkg::VALUE_W-1:0]       i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pls_pkg::ST_W-1:0]          o_status,
    output logic [pls_pkg::COUNT_W-1:0]       o_count,
    output logic [pls_pkg::ELEMENT_W-1:0]     o_element,
    output logic                              o_last
);
    import pls_pkg::*;

    // count must hold the full capacity itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SHOW = 1'b1;

    // chain of cells, front of the list in cell 0
    logic [DATA_WIDTH-1:0] w_word [CAPACITY];
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_value;
    logic [63:0]           w_value_wide;
    logic [63:0]           w_head_wide;

    logic                  r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_left,  n_left;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_status,    n_status;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;
    logic [ELEMENT_W-1:0]  r_element,   n_element;
    logic                  r_last,      n_last;

    logic                  out_free;
    logic                  in_fire;
    logic                  full;
    logic [POS_W-1:0]      cnt8;
    logic [15:0]           cnt_wide;

    // value kept to the storage width
    assign w_value_wide = 64'(i_value);
    assign w_value      = w_value_wide[DATA_WIDTH-1:0];
    // head word cut to the element field
    assign w_head_wide  = 64'(w_word[0]);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign cnt8       = POS_W'(r_count);
    assign cnt_wide   = 16'(n_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_out_count = r_out_count;
        n_element   = r_element;
        n_last      = r_last;
        w_ctl.kind  = CELL_HOLD;
        w_ctl.idx   = '0;
        w_ctl.tail  = cnt8 - POS_W'(1);

        if (r_state == S_IDLE) begin
            if (in_fire) begin
                // single result by default: element zero, marked last
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_element   = '0;
                n_last      = 1'b1;
                case (i_op)
                    OP_INS_FRONT, OP_INS_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.kind = CELL_INSERT;
                            w_ctl.idx  = (i_op == OP_INS_FRONT) ? '0 : cnt8;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    OP_INS_POS: begin
                        // position checked before fullness
                        if (i_position == '0 ||
                            {1'b0, i_position} > ({1'b0, cnt8} + 9'd1)) begin
                            n_status = ST_BADPOS;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.kind = CELL_INSERT;
                            w_ctl.idx  = i_position - POS_W'(1);
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_ctl.kind = CELL_DELETE;
                            w_ctl.idx  = (i_op == OP_DEL_FRONT) ? '0 : cnt8 - POS_W'(1);
                            n_count    = r_count - CNT_W'(1);
                        end
                    end
                    OP_DEL_POS: begin
                        // an empty list fails every position here
                        if (i_position == '0 || i_position > cnt8) begin
                            n_status = ST_BADPOS;
                        end else begin
                            w_ctl.kind = CELL_DELETE;
                            w_ctl.idx  = i_position - POS_W'(1);
                            n_count    = r_count - CNT_W'(1);
                        end
                    end
                    OP_SHOW: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // stream once the show state is entered
                            n_out_valid = 1'b0;
                            n_state     = S_SHOW;
                            n_left      = r_count;
                        end
                    end
                    default: begin
                        // unused code: plain ok result
                        n_status = ST_OK;
                    end
                endcase
                n_out_count = cnt_wide[COUNT_W-1:0];
            end
        end else if (out_free) begin
            // emit the head and rotate the live part of the chain by one;
            // after count steps the list is back in its original order
            w_ctl.kind  = CELL_ROTATE;
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_out_count = cnt_wide[COUNT_W-1:0];
            n_element   = w_head_wide[ELEMENT_W-1:0];
            n_last      = (r_left == CNT_W'(1));
            n_left      = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_lastc
                assign w_right = '0;
            end else begin : g_inner_r
                assign w_right = w_word[g+1];
            end
            pls_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_word[0]),
                .i_value (w_value),
                .o_word  (w_word[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_count <= n_out_count;
        r_element   <= n_element;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_out_count;
    assign o_element   = r_element;
    assign o_last      = r_last;

endmodule

// ===== rtl/pls_checker.sv =====
// port-level checks for the positional list store, bound to the top level
// depends on pls_pkg for status codes and on assert_macros.svh
module pls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_ready,
    input logic                          o_out_valid,
    input logic [pls_pkg::ST_W-1:0]      o_status,
    input logic [pls_pkg::COUNT_W-1:0]   o_count,
    input logic [pls_pkg::ELEMENT_W-1:0] o_element,
    input logic                          o_last
);
    import pls_pkg::*;
    `include "assert_macros.svh"

    // a stalled result stays valid and keeps its element, last flag and status
    `PLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_element) && $stable(o_last) && $stable(o_status))

    // failed requests answer once with a zero element
    `PLS_ASSERT_NOW(a_fail_single, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_last && (o_element == '0))

    // empty status only when the list holds nothing
    `PLS_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY), o_count == '0)

    // a display stream continues back to back with an unchanged count
    `PLS_ASSERT_NEXT(a_stream_next, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, o_out_valid && (o_count == $past(o_count)))

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_status    (o_status),
    .o_count     (o_count),
    .o_element   (o_element),
    .o_last      (o_last)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the positional list store
// depends on rtl/pls_pkg.sv and rtl/positional_list_store.sv; a shadow list predicts every result
module testbench;

    import pls_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int RANDOM_ITEMS   = 346;
    localparam int QUIET_ITEMS    = 60;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_PRINTED    = 40;

    // op code that the package leaves unnamed; the block answers it like a no-op
    localparam t_op OP_UNUSED = 3'd7;

    // one result as the block reports it
    typedef struct {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic [ELEMENT_W-1:0] element;
        logic                 last;
    } list_result_t;

    // shapes of the random stimulus
    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN,
        PH_NOISE
    } phase_t;

    // shadow copy of the list plus the results it owes
    class list_shadow;
        logic [DATA_WIDTH-1:0] entries[$];
        list_result_t          owed_results[$];
        int                    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int entry_count();
            return entries.size();
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        function void owe(t_status st, logic [DATA_WIDTH-1:0] element, logic last);
            list_result_t res;
            res.status  = st;
            res.count   = COUNT_W'(entries.size());
            res.element = element;
            res.last    = last;
            owed_results.push_back(res);
        endfunction

        // apply one accepted request to the shadow list and note what it owes
        function void note_request(t_op op, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] value);
            t_status st;
            int      n;
            n  = entries.size();
            st = ST_OK;
            case (op)
                OP_INS_FRONT, OP_INS_BACK: begin
                    if (n >= CAPACITY)
                        st = ST_FULL;
                    else if (op == OP_INS_FRONT)
                        entries.push_front(value);
                    else
                        entries.push_back(value);
                end
                OP_INS_POS: begin
                    // position is judged before fullness
                    if (pos < 1 || pos > n + 1)
                        st = ST_BADPOS;
                    else if (n >= CAPACITY)
                        st = ST_FULL;
                    else
                        entries.insert(pos - 1, value);
                end
                OP_DEL_FRONT, OP_DEL_BACK: begin
                    if (n == 0)
                        st = ST_EMPTY;
                    else if (op == OP_DEL_FRONT)
                        void'(entries.pop_front());
                    else
                        void'(entries.pop_back());
                end
                OP_DEL_POS: begin
                    if (pos < 1 || pos > n)
                        st = ST_BADPOS;
                    else
                        entries.delete(pos - 1);
                end
                OP_SHOW: begin
                    if (n == 0) begin
                        owe(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++)
                            owe(ST_OK, entries[i], i == n - 1);
                    end
                    return;
                end
                default: ;
            endcase
            owe(st, '0, 1'b1);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(t_status st, logic [COUNT_W-1:0] cnt,
                          logic [ELEMENT_W-1:0] element, logic last);
            list_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result st=%0d cnt=%0d elem=%h last=%0d",
                                 st, cnt, element, last));
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status || cnt !== want.count ||
                    element !== want.element || last !== want.last)
                report($sformatf("got st=%0d cnt=%0d elem=%h last=%0d, %s",
                                 st, cnt, element, last,
                                 $sformatf("want st=%0d cnt=%0d elem=%h last=%0d",
                                           want.status, want.count, want.element,
                                           want.last)));
        endtask
    endclass

    // every input is known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [OP_W-1:0]      i_op        = '0;
    logic [POS_W-1:0]     i_position  = '0;
    logic [VALUE_W-1:0]   i_value     = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [ST_W-1:0]      o_status;
    logic [COUNT_W-1:0]   o_count;
    logic [ELEMENT_W-1:0] o_element;
    logic                 o_last;

    list_shadow shadow = new();

    // idling controls set by the stimulus process, plus the receiver's stall and watchdog idle counters
    int gap_pct    = 10;
    int stall_pct  = 10;
    bit quiet      = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    positional_list_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_element   (o_element),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // receiver: ready changes on the falling edge, stalls come in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!quiet && stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // results are sampled on the rising edge, before the block updates its outputs
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(o_status, o_count, o_element, o_last);
    end

    // watchdog: too long without any handshake on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // offer one request; entered and left on a falling edge
    task automatic send_request(input t_op op, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_request(op, pos, value);
        @(negedge i_clk);
    endtask

    // hold the sender off until the block has handed back everything it owes
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (shadow.outstanding() != 0);
    endtask

    // one random request shaped by the phase and the current fill level
    task automatic pick_request(input phase_t ph, output t_op op,
                                output logic [POS_W-1:0] pos,
                                output logic [VALUE_W-1:0] value);
        int n;
        int r;
        n = shadow.entry_count();
        r = $urandom_range(0, 19);
        case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom;
        endcase
        pos = POS_W'($urandom_range(1, n + 1));
        case (ph)
            PH_FILL: begin
                if (r < 6) begin
                    op = OP_INS_FRONT;
                end else if (r < 12) begin
                    op = OP_INS_BACK;
                end else if (r < 18) begin
                    op = OP_INS_POS;
                end else if (r == 18) begin
                    op = OP_SHOW;
                end else begin
                    // position past the append slot, also tried while full
                    op  = OP_INS_POS;
                    pos = POS_W'($urandom_range(n + 2, 255));
                end
            end
            PH_DRAIN: begin
                if (r < 6) begin
                    op = OP_DEL_FRONT;
                end else if (r < 12) begin
                    op = OP_DEL_BACK;
                end else if (r < 18) begin
                    op  = OP_DEL_POS;
                    pos = POS_W'($urandom_range(1, (n > 0) ? n : 1));
                end else if (r == 18) begin
                    op = OP_SHOW;
                end else begin
                    op  = OP_DEL_POS;
                    pos = $urandom_range(0, 1) ? '0 : POS_W'($urandom_range(n + 1, 255));
                end
            end
            PH_MIXED: begin
                op = t_op'($urandom_range(OP_INS_FRONT, OP_SHOW));
            end
            default: begin
                op  = t_op'($urandom_range(OP_INS_FRONT, OP_UNUSED));
                pos = POS_W'($urandom_range(0, 255));
            end
        endcase
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    initial begin
        int          random_sent;
        int          phase_no;
        int          in_phase;
        int          phase_len;
        int          boundary_hits;
        bit          phase_over;
        phase_t      ph;
        t_op         op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;

        // synchronous reset, held at the start, once only
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: empty list, bad positions, edge values, append slot, unused op
        send_request(OP_SHOW,      8'd0,   32'h0000_0000);
        send_request(OP_DEL_FRONT, 8'd0,   32'h0000_0000);
        send_request(OP_DEL_BACK,  8'd0,   32'h0000_0000);
        send_request(OP_DEL_POS,   8'd1,   32'h0000_0000);
        send_request(OP_DEL_POS,   8'd0,   32'h0000_0000);
        send_request(OP_INS_POS,   8'd0,   32'hFFFF_FFFF);
        send_request(OP_INS_POS,   8'd2,   32'hFFFF_FFFF);
        send_request(OP_INS_POS,   8'd1,   32'h0000_0000);
        send_request(OP_INS_FRONT, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_INS_BACK,  8'd0,   32'h1234_5678);
        send_request(OP_INS_POS,   8'd2,   32'hA5A5_A5A5);
        send_request(OP_INS_POS,   8'd5,   32'h5A5A_5A5A);
        send_request(OP_INS_POS,   8'd255, 32'h0F0F_0F0F);
        send_request(OP_SHOW,      8'd0,   32'h0000_0000);
        send_request(OP_UNUSED,    8'd255, 32'hFFFF_FFFF);
        send_request(OP_DEL_POS,   8'd255, 32'h0000_0000);
        send_request(OP_DEL_POS,   8'd5,   32'h0000_0000);
        send_request(OP_DEL_POS,   8'd2,   32'h0000_0000);
        send_request(OP_DEL_POS,   8'd0,   32'h0000_0000);
        send_request(OP_DEL_FRONT, 8'd0,   32'h0000_0000);
        send_request(OP_DEL_BACK,  8'd0,   32'h0000_0000);
        send_request(OP_SHOW,      8'd0,   32'h0000_0000);
        send_request(OP_DEL_POS,   8'd1,   32'h0000_0000);
        send_request(OP_SHOW,      8'd0,   32'h0000_0000);

        // random part: fill, mixed, drain and noise phases in turn
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            ph = phase_t'(phase_no % 4);
            // the pause for all results happens at the third phase at the latest
            if (phase_no == 2 || (!quiet && $urandom_range(0, 3) == 0))
                wait_for_results();
            gap_pct       = pick_pct();
            stall_pct     = pick_pct();
            phase_len     = (ph == PH_NOISE) ? $urandom_range(6, 14) : $urandom_range(12, 30);
            in_phase      = 0;
            boundary_hits = 0;
            phase_over    = 1'b0;
            while (random_sent < RANDOM_ITEMS && !phase_over) begin
                // last stretch runs flat out on both sides
                quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
                pick_request(ph, op, pos, value);
                send_request(op, pos, value);
                random_sent++;
                in_phase++;
                if ((ph == PH_FILL && shadow.entry_count() == CAPACITY) ||
                        (ph == PH_DRAIN && shadow.entry_count() == 0))
                    boundary_hits++;
                // fill and drain phases linger a few requests at full or empty
                if (ph == PH_FILL || ph == PH_DRAIN)
                    phase_over = (boundary_hits >= 4) || (in_phase >= 60);
                else
                    phase_over = (in_phase >= phase_len);
            end
            phase_no++;
        end

        // drain what is still owed, then give the block time to show stray results
        i_in_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
